// ----- rtl/mrie_pkg.sv -----
// Shared types, opcodes and constants of the mini RISC instruction executor.
package mrie_pkg;

    // Data memory depth in words; a power of two so the word index is a bit slice.
    localparam int unsigned DMEM_WORDS = 1024;
    localparam int unsigned DMEM_AW    = $clog2(DMEM_WORDS);

    localparam int unsigned REG_COUNT = 32;
    localparam int unsigned REG_AW    = $clog2(REG_COUNT);

    localparam logic [31:0] PC_RESET = 32'd256;
    localparam logic [31:0] PC_STEP  = 32'd4;

    typedef enum logic [6:0] {
        OPC_JAL   = 7'd0,
        OPC_ADD   = 7'd1,
        OPC_ADDI  = 7'd2,
        OPC_BEQ   = 7'd3,
        OPC_SUB   = 7'd5,
        OPC_ANDI  = 7'd6,
        OPC_BNE   = 7'd7,
        OPC_AND   = 7'd9,
        OPC_ORI   = 7'd10,
        OPC_BLT   = 7'd11,
        OPC_OR    = 7'd13,
        OPC_SLL   = 7'd14,
        OPC_SW    = 7'd15,
        OPC_SRA   = 7'd18,
        OPC_LW    = 7'd22,
        OPC_BREAK = 7'd124
    } t_opcode;

    // Item kinds
    localparam logic OP_EXEC    = 1'b0;
    localparam logic OP_PRELOAD = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] instr;
        logic [31:0] preload_addr;
        logic [31:0] preload_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pc_next;
        logic        halted;
        logic        illegal;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [31:0] mem_addr;
        logic [31:0] mem_value;
    } t_out_item;

    // Execute stage result: the reported item plus architectural updates.
    typedef struct packed {
        t_out_item            res;
        logic                 is_load;
        logic [31:0]          pc_state;
        logic                 halt_next;
        logic                 dmem_we;
        logic [DMEM_AW-1:0]   dmem_idx;
    } t_exec_ctl;

endpackage

// ----- rtl/mrie_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mrie_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mrie_exec.sv -----
// Combinational execute logic: decode, ALU, branch target and memory address.
module mrie_exec (
    input  mrie_pkg::t_in_item  i_item,
    input  logic [31:0]         i_pc,
    input  logic                i_halt,
    input  logic [31:0]         i_a,
    input  logic [31:0]         i_b,
    output mrie_pkg::t_exec_ctl o_ctl
);

    always_comb begin
        logic [31:0] v_ins;
        logic [31:0] v_immi;
        logic [31:0] v_immz;
        logic [31:0] v_imms;
        logic [31:0] v_immj;
        logic [4:0]  v_sh;
        logic [31:0] v_pc4;
        logic [31:0] v_br_tgt;
        logic [31:0] v_ld_addr;
        logic [31:0] v_st_addr;

        v_ins     = i_item.instr;
        v_immi    = {{20{v_ins[31]}}, v_ins[31:20]};
        v_immz    = {20'd0, v_ins[31:20]};
        v_imms    = {{20{v_ins[31]}}, v_ins[31:25], v_ins[11:7]};
        v_immj    = {{12{v_ins[31]}}, v_ins[31:12]};
        v_sh      = v_ins[24:20];
        v_pc4     = i_pc + mrie_pkg::PC_STEP;
        v_br_tgt  = i_pc + {v_imms[30:0], 1'b0};
        v_ld_addr = i_a + v_immi;
        v_st_addr = i_b + v_imms;

        o_ctl           = '0;
        o_ctl.res.pc_next = v_pc4;
        o_ctl.halt_next = i_halt;
        o_ctl.dmem_idx  = v_ld_addr[2 +: mrie_pkg::DMEM_AW];

        if (i_item.op == mrie_pkg::OP_PRELOAD) begin
            o_ctl.dmem_we       = 1'b1;
            o_ctl.dmem_idx      = i_item.preload_addr[2 +: mrie_pkg::DMEM_AW];
            o_ctl.res.mem_write = 1'b1;
            o_ctl.res.mem_addr  = i_item.preload_addr;
            o_ctl.res.mem_value = i_item.preload_value;
            o_ctl.res.pc_next   = i_halt ? 32'd0 : i_pc;
        end else if (i_halt) begin
            o_ctl.res.pc_next = 32'd0;
        end else begin
            unique case (v_ins[6:0])
                mrie_pkg::OPC_JAL: begin
                    o_ctl.res.reg_write = 1'b1;
                    o_ctl.res.reg_value = v_pc4;
                    o_ctl.res.pc_next   = i_pc + {v_immj[30:0], 1'b0};
                end
                mrie_pkg::OPC_ADD: begin
                    o_ctl.res.reg_write = 1'b1;
                    o_ctl.res.reg_value = i_a + i_b;
                end
                mrie_pkg::OPC_ADDI: begin
                    o_ctl.res.reg_write = 1'b1;
                    o_ctl.res.reg_value = i_a + v_immi;
                end
                mrie_pkg::OPC_BEQ: begin
                    if (i_a == i_b) begin
                        o_ctl.res.pc_next = v_br_tgt;
                    end
                end
                mrie_pkg::OPC_SUB: begin
                    o_ctl.res.reg_write = 1'b1;
                    o_ctl.res.reg_value = i_a - i_b;
                end
                mrie_pkg::OPC_ANDI: begin
                    o_ctl.res.reg_write = 1'b1;
                    o_ctl.res.reg_value = i_a & v_immz;
                end
                mrie_pkg::OPC_BNE: begin
                    if (i_a != i_b) begin
                        o_ctl.res.pc_next = v_br_tgt;
                    end
                end
                mrie_pkg::OPC_AND: begin
                    o_ctl.res.reg_write = 1'b1;
                    o_ctl.res.reg_value = i_a & i_b;
                end
                mrie_pkg::OPC_ORI: begin
                    o_ctl.res.reg_write = 1'b1;
                    o_ctl.res.reg_value = i_a | v_immz;
                end
                mrie_pkg::OPC_BLT: begin
                    if ($signed(i_a) < $signed(i_b)) begin
                        o_ctl.res.pc_next = v_br_tgt;
                    end
                end
                mrie_pkg::OPC_OR: begin
                    o_ctl.res.reg_write = 1'b1;
                    o_ctl.res.reg_value = i_a | i_b;
                end
                mrie_pkg::OPC_SLL: begin
                    o_ctl.res.reg_write = 1'b1;
                    o_ctl.res.reg_value = i_a << v_sh;
                end
                mrie_pkg::OPC_SW: begin
                    o_ctl.dmem_we       = 1'b1;
                    o_ctl.dmem_idx      = v_st_addr[2 +: mrie_pkg::DMEM_AW];
                    o_ctl.res.mem_write = 1'b1;
                    o_ctl.res.mem_addr  = v_st_addr;
                    o_ctl.res.mem_value = i_a;
                end
                mrie_pkg::OPC_SRA: begin
                    o_ctl.res.reg_write = 1'b1;
                    o_ctl.res.reg_value = $unsigned($signed(i_a) >>> v_sh);
                end
                mrie_pkg::OPC_LW: begin
                    // value comes from the registered data memory read, not from this logic
                    o_ctl.res.reg_write = 1'b1;
                    o_ctl.is_load       = 1'b1;
                end
                mrie_pkg::OPC_BREAK: begin
                    o_ctl.halt_next   = 1'b1;
                    o_ctl.res.pc_next = 32'd0;
                end
                default: begin
                    o_ctl.res.illegal = 1'b1;
                end
            endcase
            if (o_ctl.res.reg_write) begin
                o_ctl.res.reg_index = v_ins[11:7];
            end
            o_ctl.pc_state = o_ctl.res.pc_next;
        end

        if (i_item.op == mrie_pkg::OP_PRELOAD || i_halt) begin
            o_ctl.pc_state = i_pc;
        end
        o_ctl.res.halted = o_ctl.halt_next;
    end

endmodule

// ----- rtl/mrie_top_dummy_placeholder.sv -----
// Register file read-operand bypass: picks the newest value of a source register.
module mrie_bypass (
    input  logic        i_out_hit,
    input  logic [31:0] i_out_val,
    input  logic        i_fwd_hit,
    input  logic [31:0] i_fwd_val,
    input  logic        i_ram_valid,
    input  logic [31:0] i_ram_val,
    output logic [31:0] o_val
);

    always_comb begin
        if (i_out_hit) begin
            o_val = i_out_val;
        end else if (i_fwd_hit) begin
            o_val = i_fwd_val;
        end else if (i_ram_valid) begin
            o_val = i_ram_val;
        end else begin
            o_val = 32'd0;
        end
    end

endmodule

// ----- rtl/mini_risc_instruction_executor.sv -----
// Top level of the mini RISC instruction executor.
//
// Executes one 32-bit instruction (or preloads one data word) per input
// transaction and returns one result transaction per input. Throughput is one
// transaction per clock: a new item is taken every cycle while the result
// register drains. The input register feeds the execute logic, whose result
// lands in the output register. The register file sits in two registered-read
// RAM copies with a valid bit per entry (an entry never written reads as zero);
// reads are issued as an item is accepted and the execute stage bypasses the
// write of the previous edge and the value still waiting in the output
// register. The data memory (DMEM_WORDS words) is a registered-read RAM:
// stores and preloads write it, and a load reads it when leaving the execute
// stage, so its value appears from the RAM output while the result waits.
// After reset the data memory is cleared one word per cycle, which holds the
// input stalled until every word is cleared. Word addresses are byte address
// bits [DMEM_AW+1:2].
module mini_risc_instruction_executor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mrie_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mrie_pkg::t_out_item o_out
);

    localparam int unsigned DAW = mrie_pkg::DMEM_AW;
    localparam int unsigned RAW = mrie_pkg::REG_AW;

    // Pipeline registers
    logic                     r_ex_valid;
    mrie_pkg::t_in_item       r_ex;
    logic                     r_out_valid;
    mrie_pkg::t_out_item      r_out;
    logic                     r_out_load;
    logic [DAW-1:0]           r_out_lidx;

    // Architectural state
    logic [31:0]              r_pc;
    logic                     r_halt;
    logic [mrie_pkg::REG_COUNT-1:0] r_rv;

    // Bypass of the register file write made at the last edge
    logic                     r_fa;
    logic                     r_fb;
    logic                     r_va;
    logic                     r_vb;
    logic [31:0]              r_fwd_val;

    // Data memory clearing pass
    logic                     r_clr_busy;
    logic [DAW:0]             r_clr_cnt;

    logic                     out_fire;
    logic                     ex_fire;
    logic                     in_fire;
    logic [31:0]              out_reg_value;
    logic                     rf_we;
    logic [RAW-1:0]           rf_widx;
    logic [31:0]              instr_sel;
    logic [RAW-1:0]           rf_ra;
    logic [RAW-1:0]           rf_rb;
    logic [31:0]              rf_qa;
    logic [31:0]              rf_qb;
    logic                     hit_out_a;
    logic                     hit_out_b;
    logic [31:0]              op_a;
    logic [31:0]              op_b;
    mrie_pkg::t_exec_ctl      ctl;
    logic                     dm_we;
    logic [DAW-1:0]           dm_waddr;
    logic [31:0]              dm_wdata;
    logic [DAW-1:0]           dm_raddr;
    logic [31:0]              dm_q;

    // Handshake: execute advances when the output register is free or draining.
    assign out_fire   = r_out_valid & ~i_out_stall;
    assign ex_fire    = r_ex_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_clr_busy | (r_ex_valid & ~ex_fire);
    assign in_fire    = i_in_valid & ~o_in_stall;

    // Result: a load takes its value straight from the data memory output.
    assign out_reg_value = r_out_load ? dm_q : r_out.reg_value;
    always_comb begin
        o_out           = r_out;
        o_out.reg_value = out_reg_value;
    end
    assign o_out_valid = r_out_valid;

    // Write back to the register file as the result transaction completes.
    assign rf_we   = out_fire & r_out.reg_write;
    assign rf_widx = r_out.reg_index;

    // Read sources of the item entering execute; re-read while execute holds.
    assign instr_sel = in_fire ? i_in.instr : r_ex.instr;
    assign rf_ra     = instr_sel[19:15];
    assign rf_rb     = instr_sel[24:20];

    mrie_ram #(
        .WIDTH (32),
        .DEPTH (mrie_pkg::REG_COUNT)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_widx),
        .i_wdata (out_reg_value),
        .i_raddr (rf_ra),
        .o_rdata (rf_qa)
    );

    mrie_ram #(
        .WIDTH (32),
        .DEPTH (mrie_pkg::REG_COUNT)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_widx),
        .i_wdata (out_reg_value),
        .i_raddr (rf_rb),
        .o_rdata (rf_qb)
    );

    // Newest first: pending result, then last edge's write, then the RAM.
    assign hit_out_a = r_out_valid & r_out.reg_write & (r_out.reg_index == r_ex.instr[19:15]);
    assign hit_out_b = r_out_valid & r_out.reg_write & (r_out.reg_index == r_ex.instr[24:20]);

    mrie_bypass u_byp_a (
        .i_out_hit   (hit_out_a),
        .i_out_val   (out_reg_value),
        .i_fwd_hit   (r_fa),
        .i_fwd_val   (r_fwd_val),
        .i_ram_valid (r_va),
        .i_ram_val   (rf_qa),
        .o_val       (op_a)
    );

    mrie_bypass u_byp_b (
        .i_out_hit   (hit_out_b),
        .i_out_val   (out_reg_value),
        .i_fwd_hit   (r_fb),
        .i_fwd_val   (r_fwd_val),
        .i_ram_valid (r_vb),
        .i_ram_val   (rf_qb),
        .o_val       (op_b)
    );

    mrie_exec u_exec (
        .i_item (r_ex),
        .i_pc   (r_pc),
        .i_halt (r_halt),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_ctl  (ctl)
    );

    // Data memory: clearing pass owns the write port until it finishes.
    always_comb begin
        if (r_clr_busy) begin
            dm_we    = 1'b1;
            dm_waddr = r_clr_cnt[DAW-1:0];
            dm_wdata = 32'd0;
        end else begin
            dm_we    = ex_fire & ctl.dmem_we;
            dm_waddr = ctl.dmem_idx;
            dm_wdata = ctl.res.mem_value;
        end
    end
    // Hold the load address so the RAM output stays put while the result waits.
    assign dm_raddr = ex_fire ? ctl.dmem_idx : r_out_lidx;

    mrie_ram #(
        .WIDTH (32),
        .DEPTH (mrie_pkg::DMEM_WORDS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_raddr (dm_raddr),
        .o_rdata (dm_q)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_load  <= 1'b0;
            r_pc        <= mrie_pkg::PC_RESET;
            r_halt      <= 1'b0;
            r_rv        <= '0;
            r_fa        <= 1'b0;
            r_fb        <= 1'b0;
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_clr_busy  <= 1'b1;
            r_clr_cnt   <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == (DAW + 1)'(mrie_pkg::DMEM_WORDS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (in_fire) begin
                r_ex_valid <= 1'b1;
            end else if (ex_fire) begin
                r_ex_valid <= 1'b0;
            end

            if (ex_fire) begin
                r_out_valid <= 1'b1;
                r_out_load  <= ctl.is_load;
                r_pc        <= ctl.pc_state;
                r_halt      <= ctl.halt_next;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end

            if (rf_we) begin
                r_rv[rf_widx] <= 1'b1;
            end

            // Status of the read captured at this edge
            r_va <= r_rv[rf_ra];
            r_vb <= r_rv[rf_rb];
            r_fa <= rf_we & (rf_widx == rf_ra);
            r_fb <= rf_we & (rf_widx == rf_rb);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ex <= i_in;
        end
        if (ex_fire) begin
            r_out      <= ctl.res;
            r_out_lidx <= ctl.dmem_idx;
        end
        r_fwd_val <= out_reg_value;
    end

endmodule

// ----- tb/mini_risc_instruction_executor_tb.sv -----
// Testbench for the mini RISC instruction executor: directed and random checking.
module mini_risc_instruction_executor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted transaction before the run is declared hung.
    // Covers the post-reset data memory clear of DMEM_WORDS words with room to spare.
    localparam int unsigned STALL_LIMIT = 5000;
    // Cycles to drain at the end, past the result and input registers.
    localparam int unsigned DRAIN_CYCLES = 10;
    // Address bits above the data memory word index.
    localparam int unsigned HI_ADDR_BITS = 32 - mrie_pkg::DMEM_AW - 2;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    mrie_pkg::t_in_item  i_in        = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    mrie_pkg::t_out_item o_out;

    // Idle and stall rates, in percent per cycle, for the current phase.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    // Architectural state the predictor keeps in step with the block.
    logic [31:0] arch_regs [mrie_pkg::REG_COUNT];
    logic [31:0] arch_dmem [mrie_pkg::DMEM_WORDS];
    logic [31:0] arch_pc;
    logic        arch_halted;

    // Results predicted for accepted transactions, oldest first.
    mrie_pkg::t_out_item pending_retires [$];
    mrie_pkg::t_out_item want;

    mini_risc_instruction_executor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: retire one transaction against the architectural state
    // and return the result the block must report for it.
    // ------------------------------------------------------------------
    function automatic mrie_pkg::t_out_item retire_item(input mrie_pkg::t_in_item it);
        mrie_pkg::t_out_item r;
        logic [31:0] ins;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] immi;
        logic [31:0] immz;
        logic [31:0] imms;
        logic [31:0] immj;
        logic [31:0] ld_addr;
        logic [4:0]  rd;
        r    = '0;
        ins  = it.instr;
        rd   = ins[11:7];
        a    = arch_regs[ins[19:15]];
        b    = arch_regs[ins[24:20]];
        immi = {{20{ins[31]}}, ins[31:20]};
        immz = {20'd0, ins[31:20]};
        imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        immj = {{12{ins[31]}}, ins[31:12]};
        if (it.op == mrie_pkg::OP_PRELOAD) begin
            // Preload goes through even while halted; the PC is only reported.
            arch_dmem[it.preload_addr[mrie_pkg::DMEM_AW+1:2]] = it.preload_value;
            r.mem_write = 1'b1;
            r.mem_addr  = it.preload_addr;
            r.mem_value = it.preload_value;
            r.pc_next   = arch_halted ? 32'd0 : arch_pc;
        end else if (arch_halted) begin
            // Halted: drop the instruction, report PC zero.
            r.pc_next = 32'd0;
        end else begin
            r.pc_next = arch_pc + mrie_pkg::PC_STEP;
            case (ins[6:0])
                mrie_pkg::OPC_JAL: begin
                    r.reg_write = 1'b1;
                    r.reg_value = arch_pc + mrie_pkg::PC_STEP;
                    r.pc_next   = arch_pc + (immj << 1);
                end
                mrie_pkg::OPC_ADD: begin
                    r.reg_write = 1'b1;
                    r.reg_value = a + b;
                end
                mrie_pkg::OPC_ADDI: begin
                    r.reg_write = 1'b1;
                    r.reg_value = a + immi;
                end
                mrie_pkg::OPC_BEQ: begin
                    if (a == b) r.pc_next = arch_pc + (imms << 1);
                end
                mrie_pkg::OPC_SUB: begin
                    r.reg_write = 1'b1;
                    r.reg_value = a - b;
                end
                mrie_pkg::OPC_ANDI: begin
                    r.reg_write = 1'b1;
                    r.reg_value = a & immz;
                end
                mrie_pkg::OPC_BNE: begin
                    if (a != b) r.pc_next = arch_pc + (imms << 1);
                end
                mrie_pkg::OPC_AND: begin
                    r.reg_write = 1'b1;
                    r.reg_value = a & b;
                end
                mrie_pkg::OPC_ORI: begin
                    r.reg_write = 1'b1;
                    r.reg_value = a | immz;
                end
                mrie_pkg::OPC_BLT: begin
                    if ($signed(a) < $signed(b)) r.pc_next = arch_pc + (imms << 1);
                end
                mrie_pkg::OPC_OR: begin
                    r.reg_write = 1'b1;
                    r.reg_value = a | b;
                end
                mrie_pkg::OPC_SLL: begin
                    r.reg_write = 1'b1;
                    r.reg_value = a << ins[24:20];
                end
                mrie_pkg::OPC_SW: begin
                    r.mem_write = 1'b1;
                    r.mem_addr  = b + imms;
                    r.mem_value = a;
                    arch_dmem[r.mem_addr[mrie_pkg::DMEM_AW+1:2]] = a;
                end
                mrie_pkg::OPC_SRA: begin
                    r.reg_write = 1'b1;
                    r.reg_value = $signed(a) >>> ins[24:20];
                end
                mrie_pkg::OPC_LW: begin
                    ld_addr     = a + immi;
                    r.reg_write = 1'b1;
                    r.reg_value = arch_dmem[ld_addr[mrie_pkg::DMEM_AW+1:2]];
                end
                mrie_pkg::OPC_BREAK: begin
                    arch_halted = 1'b1;
                    r.pc_next   = 32'd0;
                end
                default: r.illegal = 1'b1;
            endcase
            if (r.reg_write) begin
                r.reg_index   = rd;
                arch_regs[rd] = r.reg_value;
            end
            arch_pc = r.pc_next;
        end
        r.halted = arch_halted;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and field compare
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatch_count++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp_val, $realtime);
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (got !== exp_val) report_mismatch(what, got, exp_val);
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Results are checked
    // before the new input is predicted; the result retiring on this edge has
    // passed the input and output registers, so it always belongs to an earlier transaction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_retires.size() == 0) begin
                    report_mismatch("result with nothing pending", o_out.pc_next, 32'd0);
                end else begin
                    want = pending_retires.pop_front();
                    compare_field("pc_next",   o_out.pc_next,       want.pc_next);
                    compare_field("halted",    32'(o_out.halted),    32'(want.halted));
                    compare_field("illegal",   32'(o_out.illegal),   32'(want.illegal));
                    compare_field("reg_write", 32'(o_out.reg_write), 32'(want.reg_write));
                    compare_field("reg_index", 32'(o_out.reg_index), 32'(want.reg_index));
                    compare_field("reg_value", o_out.reg_value,     want.reg_value);
                    compare_field("mem_write", 32'(o_out.mem_write), 32'(want.mem_write));
                    compare_field("mem_addr",  o_out.mem_addr,      want.mem_addr);
                    compare_field("mem_value", o_out.mem_value,     want.mem_value);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                pending_retires = {pending_retires, retire_item(i_in)};
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Receiver back-pressure: stall at random at the phase's rate.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Driver: hold the transaction until it is accepted, then return at the
    // next falling edge. Valid is only lowered for an idle cycle.
    // ------------------------------------------------------------------
    task automatic send_item(input mrie_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in       <= {mrie_pkg::OP_EXEC, $urandom, $urandom, $urandom};
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Execute: preload fields are don't-care, so randomize them.
    task automatic send_exec(input logic [31:0] ins);
        send_item({mrie_pkg::OP_EXEC, ins, 32'($urandom), 32'($urandom)});
    endtask

    // Preload: the instruction field is don't-care.
    task automatic send_preload(input logic [31:0] addr, input logic [31:0] value);
        send_item({mrie_pkg::OP_PRELOAD, 32'($urandom), addr, value});
    endtask

    // ------------------------------------------------------------------
    // Instruction encoders; bits not decoded by the format are random.
    // ------------------------------------------------------------------
    function automatic logic [31:0] enc_r(input mrie_pkg::t_opcode opc, input logic [4:0] rd,
                                          input logic [4:0] s1, input logic [4:0] s2);
        logic [31:0] rnd;
        rnd = $urandom;
        return {rnd[31:25], s2, s1, rnd[14:12], rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(input mrie_pkg::t_opcode opc, input logic [4:0] rd,
                                          input logic [4:0] s1, input logic [11:0] imm);
        logic [31:0] rnd;
        rnd = $urandom;
        return {imm, s1, rnd[14:12], rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input mrie_pkg::t_opcode opc, input logic [4:0] s1,
                                          input logic [4:0] s2, input logic [11:0] imm);
        logic [31:0] rnd;
        rnd = $urandom;
        return {imm[11:5], s2, s1, rnd[14:12], imm[4:0], opc};
    endfunction

    function automatic logic [31:0] enc_j(input mrie_pkg::t_opcode opc, input logic [4:0] rd,
                                          input logic [19:0] imm);
        return {imm, rd, opc};
    endfunction

    function automatic logic opcode_defined(input logic [6:0] opc);
        case (opc)
            mrie_pkg::OPC_JAL, mrie_pkg::OPC_ADD, mrie_pkg::OPC_ADDI, mrie_pkg::OPC_BEQ,
            mrie_pkg::OPC_SUB, mrie_pkg::OPC_ANDI, mrie_pkg::OPC_BNE, mrie_pkg::OPC_AND,
            mrie_pkg::OPC_ORI, mrie_pkg::OPC_BLT, mrie_pkg::OPC_OR, mrie_pkg::OPC_SLL,
            mrie_pkg::OPC_SW, mrie_pkg::OPC_SRA, mrie_pkg::OPC_LW, mrie_pkg::OPC_BREAK:
                return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Any defined opcode except BREAK: halting is permanent, so keep it for last.
    function automatic mrie_pkg::t_opcode pick_run_op();
        case ($urandom_range(14))
            0:       return mrie_pkg::OPC_JAL;
            1:       return mrie_pkg::OPC_ADD;
            2:       return mrie_pkg::OPC_ADDI;
            3:       return mrie_pkg::OPC_BEQ;
            4:       return mrie_pkg::OPC_SUB;
            5:       return mrie_pkg::OPC_ANDI;
            6:       return mrie_pkg::OPC_BNE;
            7:       return mrie_pkg::OPC_AND;
            8:       return mrie_pkg::OPC_ORI;
            9:       return mrie_pkg::OPC_BLT;
            10:      return mrie_pkg::OPC_OR;
            11:      return mrie_pkg::OPC_SLL;
            12:      return mrie_pkg::OPC_SW;
            13:      return mrie_pkg::OPC_SRA;
            default: return mrie_pkg::OPC_LW;
        endcase
    endfunction

    // Favor a few registers so results feed later instructions.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(99) < 75) return 5'($urandom_range(7));
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [11:0] pick_imm();
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(3))
                0:       return 12'h000;
                1:       return 12'h7FF;
                2:       return 12'h800;
                default: return 12'hFFF;
            endcase
        end
        return 12'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // ALU and load paths with extreme operands; loads also cover address wrap.
    task automatic test_alu_ops();
        send_preload(32'h0000_0010, 32'h8000_0000);
        send_preload(32'hFFFF_FFFF, 32'hFFFF_FFFF);           // top word, low bits ignored
        send_exec(enc_i(mrie_pkg::OPC_LW,   5'd1,  5'd0, 12'd16));  // x1 = 0x80000000
        send_exec(enc_i(mrie_pkg::OPC_LW,   5'd2,  5'd0, 12'hFFF)); // x2 = all ones, addr wraps
        send_exec(enc_r(mrie_pkg::OPC_ADD,  5'd3,  5'd1, 5'd2));    // wraps to 0x7FFFFFFF
        send_exec(enc_r(mrie_pkg::OPC_SUB,  5'd4,  5'd1, 5'd2));
        send_exec(enc_r(mrie_pkg::OPC_AND,  5'd5,  5'd1, 5'd2));
        send_exec(enc_r(mrie_pkg::OPC_OR,   5'd6,  5'd1, 5'd2));
        send_exec(enc_i(mrie_pkg::OPC_ADDI, 5'd7,  5'd2, 12'h7FF));
        send_exec(enc_i(mrie_pkg::OPC_ANDI, 5'd8,  5'd2, 12'hFFF)); // zero-extended immediate
        send_exec(enc_i(mrie_pkg::OPC_ORI,  5'd9,  5'd0, 12'h800)); // zero-extended immediate
        send_exec(enc_i(mrie_pkg::OPC_SLL,  5'd10, 5'd2, 12'd31));
        send_exec(enc_i(mrie_pkg::OPC_SRA,  5'd11, 5'd1, 12'd31));  // sign fill
        send_exec(enc_i(mrie_pkg::OPC_SRA,  5'd12, 5'd1, 12'hFE0)); // only low 5 bits: shift 0
    endtask

    // Branches taken and not, JAL both ways, store and reload, illegal opcode,
    // and x0 behaving as an ordinary register.
    task automatic test_branches_and_memory();
        send_exec(enc_s(mrie_pkg::OPC_BEQ, 5'd0, 5'd0, 12'h800)); // taken, most negative offset
        send_exec(enc_s(mrie_pkg::OPC_BNE, 5'd1, 5'd2, 12'h7FF)); // taken, most positive offset
        send_exec(enc_s(mrie_pkg::OPC_BLT, 5'd1, 5'd3, 12'h004)); // signed: negative < positive
        send_exec(enc_s(mrie_pkg::OPC_BLT, 5'd3, 5'd1, 12'h004)); // not taken
        send_exec(enc_j(mrie_pkg::OPC_JAL, 5'd13, 20'h80000));
        send_exec(enc_j(mrie_pkg::OPC_JAL, 5'd0,  20'h7FFFF));    // writes x0
        send_exec(enc_s(mrie_pkg::OPC_SW,  5'd2, 5'd3, 12'h7FF));
        send_exec(enc_i(mrie_pkg::OPC_LW,  5'd14, 5'd3, 12'h7FF));
        send_exec(32'hFFFF_FFFF);                                  // undefined opcode
        send_exec(enc_r(mrie_pkg::OPC_ADD, 5'd15, 5'd0, 5'd0));   // reads back nonzero x0
    endtask

    // Random mix: store/load and preload/load pairs plus random instructions,
    // with raw preloads and undefined opcodes as noise.
    task automatic test_random_mix(input int unsigned n_items, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
        int unsigned sent;
        int unsigned pick;
        logic [4:0]  rb;
        logic [4:0]  rd;
        logic [11:0] imm;
        logic [31:0] addr;
        logic [31:0] ins;
        logic [6:0]  bad_opc;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                // Store, then load back through the same base and offset.
                rb  = pick_reg();
                rd  = pick_reg();
                imm = pick_imm();
                send_exec(enc_s(mrie_pkg::OPC_SW, pick_reg(), rb, imm));
                send_exec(enc_i(mrie_pkg::OPC_LW, rd, rb, imm));
                sent += 2;
            end else if (pick < 30) begin
                // Preload the word a load will hit; vary the ignored address bits.
                rb   = pick_reg();
                rd   = pick_reg();
                imm  = pick_imm();
                addr = arch_regs[rb] + {{20{imm[11]}}, imm};
                addr[1:0] = 2'($urandom_range(3));
                if ($urandom_range(1) != 0) begin
                    addr[31:mrie_pkg::DMEM_AW+2] = HI_ADDR_BITS'($urandom);
                end
                send_preload(addr, $urandom);
                send_exec(enc_i(mrie_pkg::OPC_LW, rd, rb, imm));
                sent += 2;
            end else if (pick < 38) begin
                send_preload($urandom, $urandom);
                sent++;
            end else if (pick < 43) begin
                do bad_opc = 7'($urandom_range(127)); while (opcode_defined(bad_opc));
                ins      = $urandom;
                ins[6:0] = bad_opc;
                send_exec(ins);
                sent++;
            end else begin
                ins         = $urandom;
                ins[6:0]    = pick_run_op();
                ins[11:7]   = pick_reg();
                ins[19:15]  = pick_reg();
                ins[24:20]  = pick_reg();
                if ($urandom_range(3) == 0) ins[31:20] = pick_imm();
                // Same source twice makes BEQ take and BNE fall through.
                if ($urandom_range(4) == 0) ins[24:20] = ins[19:15];
                send_exec(ins);
                sent++;
            end
        end
    endtask

    // BREAK, then an instruction and a preload while halted. Halt is permanent,
    // so this runs last.
    task automatic test_halt();
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        send_exec(enc_i(mrie_pkg::OPC_BREAK, 5'd0, 5'd0, 12'd0));
        send_exec(enc_r(mrie_pkg::OPC_ADD, 5'd1, 5'd2, 5'd3));
        send_preload(32'h0000_0100, 32'hA5A5_5A5A);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < mrie_pkg::REG_COUNT; i++) arch_regs[i] = '0;
        for (int i = 0; i < mrie_pkg::DMEM_WORDS; i++) arch_dmem[i] = '0;
        arch_pc     = mrie_pkg::PC_RESET;
        arch_halted = 1'b0;

        // Hold reset, then release it on a falling edge.
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_alu_ops();
        test_branches_and_memory();
        test_random_mix(490, 0, 0);
        test_random_mix(490, 50, 0);
        test_random_mix(490, 0, 50);
        test_random_mix(490, 6, 6);
        test_halt();
        i_in_valid <= 1'b0;

        // Drain: the watchdog bounds this wait.
        while (pending_retires.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
